// File: rtl/smoothed_triangle_wave_pixel_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the smoothed triangle wave pixel generator
// Concurrent checks on the rising clock edge, masked while reset is low.
// ----------------------------------------------------------------------------
`ifndef SMOOTHED_TRIANGLE_WAVE_PIXEL_TOP_MACROS_SVH
`define SMOOTHED_TRIANGLE_WAVE_PIXEL_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define STW_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("stw assertion failed");
`define STW_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("stw assertion failed");
`else
`define STW_ASSERT(name, clk, rst_n, prop)
`define STW_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/stw_pkg.sv
// ----------------------------------------------------------------------------
// stw_pkg
// Shared widths, register indexes, config bundle and divider step function.
// ----------------------------------------------------------------------------
`default_nettype none

package stw_pkg;

	localparam int WN_W       = 16;
	localparam int ANG_W      = 16;
	localparam int SLANT_W    = 16;
	localparam int STEP_W     = 24;
	localparam int PHASE_W    = 24;
	localparam int COORD_W    = 10;
	localparam int DISP_W     = 24;
	localparam int HEIGHT_W   = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int XC_W    = STEP_W + COORD_W;
	localparam int PRODF_W = ANG_W + XC_W + 1;
	localparam int P_W     = 47;
	localparam int P_LO_W  = 24;
	localparam int P_HI_W  = P_W - P_LO_W;
	localparam int MLO_W   = P_LO_W + WN_W;
	localparam int FRAC_W  = 16;
	localparam int FRAC_LSB = 31;
	localparam int DISP_SH = 23;

	localparam int Q_W      = 16;
	localparam int DEN_W    = 17;
	localparam int DIV_STEP = 4;
	localparam int T_W      = 18;
	localparam int R2_W     = 32;

	localparam logic [DEN_W-1:0] ONE_Q16   = 17'h10000;
	localparam logic [T_W-1:0]   THREE_Q16 = 18'd196608;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WAVENUMBER   = 3'd0,
		CFG_COS_ANGLE    = 3'd1,
		CFG_SIN_ANGLE    = 3'd2,
		CFG_RISE_SHARE   = 3'd3,
		CFG_X_STEP       = 3'd4,
		CFG_Y_STEP       = 3'd5,
		CFG_PHASE_OFFSET = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic        [WN_W-1:0]    wavenumber;
		logic signed [ANG_W-1:0]   cos_angle;
		logic signed [ANG_W-1:0]   sin_angle;
		logic        [SLANT_W-1:0] rise_share;
		logic        [STEP_W-1:0]  x_step;
		logic        [STEP_W-1:0]  y_step;
		logic signed [PHASE_W-1:0] phase_offset;
	} cfg_t;

	// restoring division state: remainder stays below den
	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [Q_W-1:0]   quo;
		logic [DEN_W-1:0] den;
		logic             fall;
	} div_t;

	function automatic div_t div_step(input div_t d);
		div_t             o;
		logic [DEN_W-1:0] sh;
		o = d;
		for (int i = 0; i < DIV_STEP; i++) begin
			sh = {o.rem[DEN_W-2:0], 1'b0};
			if (sh >= o.den) begin
				o.rem = sh - o.den;
				o.quo = {o.quo[Q_W-2:0], 1'b1};
			end else begin
				o.rem = sh;
				o.quo = {o.quo[Q_W-2:0], 1'b0};
			end
		end
		return o;
	endfunction

endpackage

`default_nettype wire

// File: rtl/smoothed_triangle_wave_pixel_top.sv
// ----------------------------------------------------------------------------
// smoothed_triangle_wave_pixel_top
// Smoothed triangle wave pixel generator. Takes one pixel word (column, row,
// displacement) per clock while in_ready is high and returns one height word
// per pixel, in order. The pipeline has twelve register stages: five for the
// projection and the wavenumber scaling, five for the ramp select and a
// 16-bit restoring divide (four quotient bits per stage), and two for the
// smoothstep; the last stage is the output register. All stages advance
// together whenever the output register is empty or being taken, so in_ready
// depends only on out_valid and out_ready, and a sustained stream runs at one
// word per clock.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// are to be changed only while no word is in flight.
// ----------------------------------------------------------------------------
`default_nettype none
`include "smoothed_triangle_wave_pixel_top_macros.svh"

module smoothed_triangle_wave_pixel_top import stw_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [COORD_W-1:0]    column,
	input  wire logic [COORD_W-1:0]    row,
	input  wire logic [DISP_W-1:0]     displacement,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [HEIGHT_W-1:0]        height
);

	cfg_t              cfg_q;
	logic              en;
	logic              frac_valid;
	logic [FRAC_W-1:0] frac;
	logic              rmp_valid;
	div_t              rmp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wavenumber   <= 16'd512;
			cfg_q.cos_angle    <= 16'sd32767;
			cfg_q.sin_angle    <= '0;
			cfg_q.rise_share   <= 16'd32768;
			cfg_q.x_step       <= 24'd16384;
			cfg_q.y_step       <= 24'd16384;
			cfg_q.phase_offset <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WAVENUMBER:   cfg_q.wavenumber   <= cfg_data[WN_W-1:0];
				CFG_COS_ANGLE:    cfg_q.cos_angle    <= cfg_data[ANG_W-1:0];
				CFG_SIN_ANGLE:    cfg_q.sin_angle    <= cfg_data[ANG_W-1:0];
				CFG_RISE_SHARE:   cfg_q.rise_share   <= cfg_data[SLANT_W-1:0];
				CFG_X_STEP:       cfg_q.x_step       <= cfg_data[STEP_W-1:0];
				CFG_Y_STEP:       cfg_q.y_step       <= cfg_data[STEP_W-1:0];
				CFG_PHASE_OFFSET: cfg_q.phase_offset <= cfg_data[PHASE_W-1:0];
				default: ;
			endcase
		end
	end

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	stw_proj u_proj (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.column       (column),
		.row          (row),
		.displacement (displacement),
		.frac_valid   (frac_valid),
		.frac         (frac)
	);

	stw_ramp u_ramp (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.rise_share (cfg_q.rise_share),
		.frac_valid (frac_valid),
		.frac       (frac),
		.div_valid  (rmp_valid),
		.div_res    (rmp)
	);

	stw_smooth u_smooth (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.div_valid (rmp_valid),
		.div_res   (rmp),
		.out_valid (out_valid),
		.height    (height)
	);

	`STW_ASSERT(a_div_rem_below_den, clk, arst_n, rmp_valid |-> (rmp.rem < rmp.den))
	`STW_ASSERT(a_rise_den, clk, arst_n, (rmp_valid && !rmp.fall) |-> (rmp.den == DEN_W'(cfg_q.rise_share)))
	`STW_ASSERT(a_fall_den, clk, arst_n, (rmp_valid && rmp.fall) |-> (rmp.den == ONE_Q16 - DEN_W'(cfg_q.rise_share)))
	`STW_ASSERT_NEXT(a_div_hold, clk, arst_n, rmp_valid && !en, rmp_valid && $stable(rmp))

endmodule

`default_nettype wire

// File: rtl/stw_proj.sv
// ----------------------------------------------------------------------------
// stw_proj
// Projection and wavenumber scaling, stages 1 to 5; yields the Q0.16 fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module stw_proj import stw_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire cfg_t                cfg,
	input  wire logic                in_valid,
	input  wire logic [COORD_W-1:0]  column,
	input  wire logic [COORD_W-1:0]  row,
	input  wire logic [DISP_W-1:0]   displacement,
	output logic                     frac_valid,
	output logic [FRAC_W-1:0]        frac
);

	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [XC_W-1:0]   xc_s1, yr_s1;
	logic [DISP_W-1:0] dp_s1, dp_s2;
	logic [P_W-1:0]    px_s2, py_s2;
	logic [P_W-1:0]    p_s3;
	logic [P_HI_W-1:0] mhi_s4;
	logic [MLO_W-1:0]  mlo_s4;
	logic [FRAC_W-1:0] frac_s5;

	logic signed [PRODF_W-1:0] pxf, pyf;
	logic [P_W-1:0]            sum;

	always_comb begin
		pxf = $signed(cfg.cos_angle) * $signed({1'b0, xc_s1});
		pyf = $signed(cfg.sin_angle) * $signed({1'b0, yr_s1});
		sum = {mhi_s4, {P_LO_W{1'b0}}} + P_W'(mlo_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xc_s1   <= XC_W'(cfg.x_step) * XC_W'(column);
			yr_s1   <= XC_W'(cfg.y_step) * XC_W'(row);
			dp_s1   <= displacement + cfg.phase_offset;
			px_s2   <= pxf[P_W-1:0];
			py_s2   <= pyf[P_W-1:0];
			dp_s2   <= dp_s1;
			p_s3    <= px_s2 + py_s2 + {dp_s2, {DISP_SH{1'b0}}};
			mhi_s4  <= p_s3[P_W-1:P_LO_W] * P_HI_W'(cfg.wavenumber);
			mlo_s4  <= MLO_W'(p_s3[P_LO_W-1:0]) * MLO_W'(cfg.wavenumber);
			frac_s5 <= sum[FRAC_LSB+FRAC_W-1:FRAC_LSB];
		end
	end

	assign frac_valid = v_s5;
	assign frac       = frac_s5;

endmodule

`default_nettype wire

// File: rtl/stw_ramp.sv
// ----------------------------------------------------------------------------
// stw_ramp
// Rising/falling ramp select and pipelined divide, stages 6 to 10.
// ----------------------------------------------------------------------------
`default_nettype none

module stw_ramp import stw_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic [SLANT_W-1:0] rise_share,
	input  wire logic              frac_valid,
	input  wire logic [FRAC_W-1:0] frac,
	output logic                   div_valid,
	output div_t                   div_res
);

	logic v_s6, v_s7, v_s8, v_s9, v_s10;
	div_t dv_s6, dv_s7, dv_s8, dv_s9, dv_s10;
	div_t sel;

	always_comb begin
		sel.quo = '0;
		if (frac < rise_share) begin
			sel.rem  = DEN_W'(frac);
			sel.den  = DEN_W'(rise_share);
			sel.fall = 1'b0;
		end else begin
			sel.rem  = DEN_W'(frac - rise_share);
			sel.den  = ONE_Q16 - DEN_W'(rise_share);
			sel.fall = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s6  <= frac_valid;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s6  <= sel;
			dv_s7  <= div_step(dv_s6);
			dv_s8  <= div_step(dv_s7);
			dv_s9  <= div_step(dv_s8);
			dv_s10 <= div_step(dv_s9);
		end
	end

	assign div_valid = v_s10;
	assign div_res   = dv_s10;

endmodule

`default_nettype wire

// File: rtl/stw_smooth.sv
// ----------------------------------------------------------------------------
// stw_smooth
// Smoothstep r*r*(3-2r) with peak saturation, stages 11 and 12.
// ----------------------------------------------------------------------------
`default_nettype none

module stw_smooth import stw_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 div_valid,
	input  wire div_t                 div_res,
	output logic                      out_valid,
	output logic [HEIGHT_W-1:0]       height
);

	logic                v_s11, v_s12;
	logic                peak_s11;
	logic [R2_W-1:0]     r2_s11;
	logic [T_W-1:0]      t_s11;
	logic [HEIGHT_W-1:0] height_s12;

	logic [DEN_W-1:0]     r;
	logic [R2_W+T_W-1:0]  prod;

	always_comb begin
		if (div_res.fall)
			r = ONE_Q16 - DEN_W'(div_res.quo);
		else
			r = DEN_W'(div_res.quo);
		prod = (R2_W+T_W)'(r2_s11) * (R2_W+T_W)'(t_s11);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s11 <= div_valid;
			v_s12 <= v_s11;
		end
	end

	// r == 1.0 is the only input that reaches 65536
	always_ff @(posedge clk) begin
		if (en) begin
			peak_s11   <= r[DEN_W-1];
			r2_s11     <= R2_W'(r[DEN_W-2:0]) * R2_W'(r[DEN_W-2:0]);
			t_s11      <= THREE_Q16 - {r, 1'b0};
			height_s12 <= peak_s11 ? '1 : prod[R2_W+HEIGHT_W-1:R2_W];
		end
	end

	assign out_valid = v_s12;
	assign height    = height_s12;

endmodule

`default_nettype wire
